/* rtl/ctsp_pkg.sv */
// Shared types and constants for the cue timestamp parser.
// Used by the front parser, the request queue, the back end and the top level.
package ctsp_pkg;

    // Longest hours field accepted, in digits
    localparam int MAX_HOUR_DIGITS = 9;

    // Field widths
    localparam int FIRST_W  = 30;
    localparam int FCOUNT_W = 4;
    localparam int SEC_W    = 7;
    localparam int MILLI_W  = 10;
    localparam int CHARS_W  = 5;
    localparam int TIME_W   = 52;
    localparam int MIN_W    = 22;
    localparam int SMS_W    = 16;

    // Milliseconds per unit
    localparam logic [TIME_W-1:0] MS_PER_HOUR = TIME_W'(3600000);
    localparam logic [MIN_W-1:0]  MS_PER_MIN  = MIN_W'(60000);
    localparam logic [SMS_W-1:0]  MS_PER_SEC  = SMS_W'(1000);
    localparam logic [SEC_W-1:0]  MAX_MIN_SEC = SEC_W'(59);

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Saturation limit of the character count
    localparam logic [CHARS_W-1:0] CHARS_MAX = '1;

    // Request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Parser phase
    typedef enum logic [2:0] {
        PH_FIRST0,
        PH_FIRST,
        PH_SEC0,
        PH_SEC,
        PH_THIRD0,
        PH_THIRD,
        PH_MS0,
        PH_MS
    } ctsp_phase_t;

    // One result request handed from front to back
    typedef struct packed {
        logic                check;
        logic                hours;
        logic [FIRST_W-1:0]  first;
        logic [SEC_W-1:0]    second;
        logic [SEC_W-1:0]    third;
        logic [MILLI_W-1:0]  milli;
        logic [CHARS_W-1:0]  chars;
    } ctsp_req_t;

endpackage

/* rtl/cue_timestamp_parser_core.sv */
// Cue timestamp parser top level: front parser, request queue, arithmetic back end.
// A result passes the queue entry, the product register and the output (sum) register,
// and m_axis_tvalid rises once the result reaches the output register.
// Throughput: one character per cycle, set by the parse step in the front;
// s_axis_tready drops only while the four-entry request queue is full.
// Reset: rst_n clears the parse state, queue and output valid; the block then awaits a
// first digit with no pending result.
module cue_timestamp_parser_core
    import ctsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [51:0] time_ms, [56:52] chars_used, rest zero
    output logic        m_axis_tuser    // valid_res
);

    logic                q_full;
    logic                q_push;
    ctsp_req_t           push_data;
    ctsp_req_t           head_data;
    logic                head_valid;
    logic                pop;
    logic [TIME_W-1:0]   time_ms;
    logic [CHARS_W-1:0]  chars_used;

    ctsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .ch       (s_axis_tdata),
        .eot      (s_axis_tlast),
        .in_ready (s_axis_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    ctsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    ctsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .time_ms    (time_ms),
        .valid_res  (m_axis_tuser),
        .chars_used (chars_used)
    );

    // Pack the result
    assign m_axis_tdata = {7'd0, chars_used, time_ms};

    // A malformed result carries no time and no count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("malformed result with nonzero payload");

    // A well-formed timestamp spans at least mm:ss.ttt
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (chars_used >= CHARS_W'(9)))
        else $error("well-formed result with too few characters");

    // The front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

endmodule

/* rtl/ctsp_front.sv */
// Front end: accepts characters, runs the timestamp pattern and issues result requests.
// Depends on ctsp_pkg.
module ctsp_front
    import ctsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  ch,
    input  logic        eot,
    output logic        in_ready,
    input  logic        q_full,
    output logic        q_push,
    output ctsp_req_t   q_data
);

    ctsp_phase_t         phase_reg, phase_next;
    logic                hours_reg, hours_next;
    logic [FIRST_W-1:0]  first_reg, first_next;
    logic [FCOUNT_W-1:0] fcount_reg, fcount_next;
    logic [SEC_W-1:0]    second_reg, second_next;
    logic [SEC_W-1:0]    third_reg, third_next;
    logic [MILLI_W-1:0]  milli_reg, milli_next;
    logic [1:0]          fldcnt_reg, fldcnt_next;
    logic [CHARS_W-1:0]  chars_reg, chars_next;
    logic                wait_reg, wait_next;

    logic       accept;
    logic       is_digit;
    logic [3:0] dval;
    logic       is_colon;
    logic       is_dot;
    logic       char_step;
    logic       take_dig;
    logic       sep;
    logic       done;
    logic       bad;
    logic       ms_full;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dval      = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
    assign is_colon  = (ch == CH_COLON);
    assign is_dot    = (ch == CH_DOT);
    assign char_step = accept && !eot && !wait_reg;
    assign ms_full   = (phase_reg == PH_MS) && (fldcnt_reg == 2'd3);

    // Classify the current character against the expected pattern
    always_comb
    begin
        take_dig = 1'b0;
        sep      = 1'b0;
        done     = 1'b0;
        bad      = 1'b0;
        case (phase_reg)
            PH_FIRST0, PH_FIRST:
            begin
                if (is_digit)
                begin
                    if (fcount_reg >= FCOUNT_W'(MAX_HOUR_DIGITS))
                        bad = 1'b1;
                    else
                        take_dig = 1'b1;
                end
                else if (phase_reg == PH_FIRST && is_colon)
                    sep = 1'b1;
                else
                    bad = 1'b1;
            end
            PH_SEC0, PH_SEC:
            begin
                if (is_digit)
                begin
                    if (fldcnt_reg >= 2'd2)
                        bad = 1'b1;
                    else
                        take_dig = 1'b1;
                end
                else if (phase_reg == PH_SEC && fldcnt_reg == 2'd2 && is_colon)
                    sep = 1'b1;
                else if (phase_reg == PH_SEC && fldcnt_reg == 2'd2 && is_dot && !hours_reg)
                    sep = 1'b1;
                else
                    bad = 1'b1;
            end
            PH_THIRD0, PH_THIRD:
            begin
                if (is_digit)
                begin
                    if (fldcnt_reg >= 2'd2)
                        bad = 1'b1;
                    else
                        take_dig = 1'b1;
                end
                else if (phase_reg == PH_THIRD && fldcnt_reg == 2'd2 && is_dot)
                    sep = 1'b1;
                else
                    bad = 1'b1;
            end
            default:
            begin
                if (is_digit)
                begin
                    if (fldcnt_reg == 2'd3)
                        bad = 1'b1;
                    else
                        take_dig = 1'b1;
                end
                else if (ms_full)
                    done = 1'b1;
                else
                    bad = 1'b1;
            end
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && eot)
            phase_next = PH_FIRST0;
        else if (char_step && take_dig)
        begin
            case (phase_reg)
                PH_FIRST0, PH_FIRST: phase_next = PH_FIRST;
                PH_SEC0, PH_SEC:     phase_next = PH_SEC;
                PH_THIRD0, PH_THIRD: phase_next = PH_THIRD;
                default:             phase_next = PH_MS;
            endcase
        end
        else if (char_step && sep)
        begin
            case (phase_reg)
                PH_FIRST:  phase_next = PH_SEC0;
                PH_SEC:    phase_next = is_colon ? PH_THIRD0 : PH_MS0;
                default:   phase_next = PH_MS0;
            endcase
        end
    end

    // Field updates and result requests
    always_comb
    begin
        hours_next  = hours_reg;
        first_next  = first_reg;
        fcount_next = fcount_reg;
        second_next = second_reg;
        third_next  = third_reg;
        milli_next  = milli_reg;
        fldcnt_next = fldcnt_reg;
        chars_next  = chars_reg;
        wait_next   = wait_reg;
        q_push      = 1'b0;

        q_data.check  = ms_full;
        q_data.hours  = hours_reg;
        q_data.first  = first_reg;
        q_data.second = second_reg;
        q_data.third  = third_reg;
        q_data.milli  = milli_reg;
        q_data.chars  = chars_reg;

        if (accept && eot)
        begin
            // End of text: report unless only re-arming, then clear the parse
            q_push      = !wait_reg;
            wait_next   = 1'b0;
            hours_next  = 1'b0;
            first_next  = '0;
            fcount_next = '0;
            second_next = '0;
            third_next  = '0;
            milli_next  = '0;
            fldcnt_next = '0;
            chars_next  = '0;
        end
        else if (char_step)
        begin
            if (done || bad)
            begin
                // Report and hold until end of text
                q_push       = 1'b1;
                q_data.check = done;
                wait_next    = 1'b1;
            end
            else
            begin
                if (take_dig)
                begin
                    case (phase_reg)
                        PH_FIRST0, PH_FIRST:
                        begin
                            first_next  = first_reg * FIRST_W'(10) + FIRST_W'(dval);
                            fcount_next = fcount_reg + 1'b1;
                        end
                        PH_SEC0, PH_SEC:
                        begin
                            second_next = second_reg * SEC_W'(10) + SEC_W'(dval);
                            fldcnt_next = fldcnt_reg + 1'b1;
                        end
                        PH_THIRD0, PH_THIRD:
                        begin
                            third_next  = third_reg * SEC_W'(10) + SEC_W'(dval);
                            fldcnt_next = fldcnt_reg + 1'b1;
                        end
                        default:
                        begin
                            milli_next  = milli_reg * MILLI_W'(10) + MILLI_W'(dval);
                            fldcnt_next = fldcnt_reg + 1'b1;
                        end
                    endcase
                end
                else
                begin
                    // Separator: start the next field, decide hours mode
                    fldcnt_next = '0;
                    if (phase_reg == PH_FIRST)
                    begin
                        if (fcount_reg != FCOUNT_W'(2) ||
                            first_reg > FIRST_W'(MAX_MIN_SEC))
                            hours_next = 1'b1;
                    end
                    else if (phase_reg == PH_SEC && is_colon)
                        hours_next = 1'b1;
                end
                if (chars_reg != CHARS_MAX)
                    chars_next = chars_reg + 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST0;
            hours_reg  <= 1'b0;
            first_reg  <= '0;
            fcount_reg <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            milli_reg  <= '0;
            fldcnt_reg <= '0;
            chars_reg  <= '0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hours_reg  <= hours_next;
            first_reg  <= first_next;
            fcount_reg <= fcount_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            milli_reg  <= milli_next;
            fldcnt_reg <= fldcnt_next;
            chars_reg  <= chars_next;
            wait_reg   <= wait_next;
        end
    end

endmodule

/* rtl/ctsp_queue.sv */
// Short request queue between the parser front and the arithmetic back end.
// Depends on ctsp_pkg.
module ctsp_queue
    import ctsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ctsp_req_t  push_data,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output ctsp_req_t  head_data
);

    ctsp_req_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/ctsp_back.sv */
// Back end: range check, millisecond products, final sum and output register.
// Depends on ctsp_pkg.
module ctsp_back
    import ctsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ctsp_req_t           head_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TIME_W-1:0]   time_ms,
    output logic                valid_res,
    output logic [CHARS_W-1:0]  chars_used
);

    // Product stage
    logic                s1_valid_reg, s1_valid_next;
    logic [TIME_W-1:0]   s1_hour_reg;
    logic [MIN_W-1:0]    s1_min_reg;
    logic [SMS_W-1:0]    s1_sms_reg;
    logic                s1_ok_reg;
    logic [CHARS_W-1:0]  s1_chars_reg;

    // Output stage
    logic                o_valid_reg, o_valid_next;
    logic [TIME_W-1:0]   o_time_reg;
    logic                o_ok_reg;
    logic [CHARS_W-1:0]  o_chars_reg;

    logic                o_free;
    logic                s1_load;
    logic [FIRST_W-1:0]  h_val;
    logic [SEC_W-1:0]    m_val;
    logic [SEC_W-1:0]    s_val;
    logic                in_range;
    logic                ok;

    assign o_free  = !o_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || o_free;
    assign pop     = head_valid && s1_load;

    // Select hours, minutes and seconds by mode and check ranges
    always_comb
    begin
        if (head_data.hours)
        begin
            h_val = head_data.first;
            m_val = head_data.second;
            s_val = head_data.third;
        end
        else
        begin
            h_val = '0;
            m_val = SEC_W'(head_data.first);
            s_val = head_data.second;
        end
        in_range = (m_val <= MAX_MIN_SEC) && (s_val <= MAX_MIN_SEC) &&
                   (head_data.hours || head_data.first <= FIRST_W'(MAX_MIN_SEC));
        ok = head_data.check && in_range;
    end

    assign s1_valid_next = s1_load ? head_valid : s1_valid_reg;
    assign o_valid_next  = o_free ? s1_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Register the products; zero everything for a malformed result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ok_reg    <= ok;
            s1_hour_reg  <= ok ? TIME_W'(h_val) * MS_PER_HOUR : '0;
            s1_min_reg   <= ok ? MIN_W'(m_val) * MS_PER_MIN : '0;
            s1_sms_reg   <= ok ? SMS_W'(s_val) * MS_PER_SEC + SMS_W'(head_data.milli) : '0;
            s1_chars_reg <= ok ? head_data.chars : '0;
        end
    end

    // Sum into the output register
    always_ff @(posedge clk)
    begin
        if (o_free && s1_valid_reg)
        begin
            o_time_reg  <= s1_hour_reg + TIME_W'(s1_min_reg) + TIME_W'(s1_sms_reg);
            o_ok_reg    <= s1_ok_reg;
            o_chars_reg <= s1_chars_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign time_ms    = o_time_reg;
    assign valid_res  = o_ok_reg;
    assign chars_used = o_chars_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for cue_timestamp_parser_core: streams characters into s_axis,
// predicts each timestamp result in a local parser model and checks every m_axis transfer.
// Depends on ctsp_pkg for the parse phase type, character codes and MAX_HOUR_DIGITS.
module testbench
    import ctsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL   = 650;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    // One parsed timestamp as seen on m_axis
    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic               valid_res;
        logic [CHARS_W-1:0] chars_used;
    } cue_res_t;

    // One character transfer on s_axis
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } char_item_t;

    // Directed row: transfer plus an optional hand-written result
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        cue_res_t   want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    cue_timestamp_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Parser model state
    ctsp_phase_t        prs_phase;
    logic               hrs_mode;
    logic [FIRST_W-1:0] fld_first;
    logic [3:0]         first_digits;
    logic [SEC_W-1:0]   fld_second;
    logic [SEC_W-1:0]   fld_third;
    logic [MILLI_W-1:0] fld_milli;
    logic [2:0]         digit_cnt;
    logic [CHARS_W-1:0] used_chars;
    logic               rearm_wait;

    cue_res_t   pending_stamps[$];
    char_item_t char_stream[$];
    dir_row_t   dir_rows[$];

    int mismatches;
    int quiet_cycles;
    int src_idle_pct;
    int snk_stall_pct;

    // Clock: 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void clear_parse();
        prs_phase    = PH_FIRST0;
        hrs_mode     = 1'b0;
        fld_first    = '0;
        first_digits = '0;
        fld_second   = '0;
        fld_third    = '0;
        fld_milli    = '0;
        digit_cnt    = '0;
        used_chars   = '0;
    endfunction

    // Range-check the fields and convert to milliseconds
    function automatic cue_res_t fraction_result();
        logic [63:0] hh;
        logic [63:0] mm;
        logic [63:0] ss;
        cue_res_t    r;
        if (hrs_mode)
        begin
            hh = 64'(fld_first);
            mm = 64'(fld_second);
            ss = 64'(fld_third);
        end
        else
        begin
            hh = '0;
            mm = 64'(fld_first);
            ss = 64'(fld_second);
        end
        r = '0;
        if (mm <= 64'(MAX_MIN_SEC) && ss <= 64'(MAX_MIN_SEC))
        begin
            r.time_ms    = TIME_W'(hh * 3600000 + mm * 60000 + ss * 1000 + 64'(fld_milli));
            r.valid_res  = 1'b1;
            r.chars_used = used_chars;
        end
        return r;
    endfunction

    // Advance the parser model by one accepted transfer
    task automatic parse_step(input logic [7:0] ch, input logic eot,
                              output logic emitted, output cue_res_t res);
        logic       is_dig;
        logic       bad;
        logic [3:0] d;
        is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d       = is_dig ? 4'(ch - CH_ZERO) : 4'd0;
        bad     = 1'b0;
        emitted = 1'b0;
        res     = '0;
        if (eot)
        begin
            if (rearm_wait)
                rearm_wait = 1'b0;
            else
            begin
                emitted = 1'b1;
                if (prs_phase == PH_MS && digit_cnt == 3'd3)
                    res = fraction_result();
            end
            clear_parse();
        end
        else if (!rearm_wait)
        begin
            case (prs_phase)
                PH_FIRST0, PH_FIRST:
                begin
                    if (is_dig)
                    begin
                        if (first_digits >= MAX_HOUR_DIGITS)
                            bad = 1'b1;
                        else
                        begin
                            fld_first    = FIRST_W'(fld_first * 10 + d);
                            first_digits = first_digits + 1'b1;
                            prs_phase    = PH_FIRST;
                        end
                    end
                    else if (prs_phase == PH_FIRST && ch == CH_COLON)
                    begin
                        if (first_digits != 4'd2 || fld_first > FIRST_W'(MAX_MIN_SEC))
                            hrs_mode = 1'b1;
                        prs_phase = PH_SEC0;
                        digit_cnt = '0;
                    end
                    else
                        bad = 1'b1;
                end
                PH_SEC0, PH_SEC:
                begin
                    if (is_dig)
                    begin
                        if (digit_cnt >= 3'd2)
                            bad = 1'b1;
                        else
                        begin
                            fld_second = SEC_W'(fld_second * 10 + d);
                            digit_cnt  = digit_cnt + 1'b1;
                            prs_phase  = PH_SEC;
                        end
                    end
                    else if (prs_phase == PH_SEC && digit_cnt == 3'd2 && ch == CH_COLON)
                    begin
                        hrs_mode  = 1'b1;
                        prs_phase = PH_THIRD0;
                        digit_cnt = '0;
                    end
                    else if (prs_phase == PH_SEC && digit_cnt == 3'd2 && ch == CH_DOT
                             && !hrs_mode)
                    begin
                        prs_phase = PH_MS0;
                        digit_cnt = '0;
                    end
                    else
                        bad = 1'b1;
                end
                PH_THIRD0, PH_THIRD:
                begin
                    if (is_dig)
                    begin
                        if (digit_cnt >= 3'd2)
                            bad = 1'b1;
                        else
                        begin
                            fld_third = SEC_W'(fld_third * 10 + d);
                            digit_cnt = digit_cnt + 1'b1;
                            prs_phase = PH_THIRD;
                        end
                    end
                    else if (prs_phase == PH_THIRD && digit_cnt == 3'd2 && ch == CH_DOT)
                    begin
                        prs_phase = PH_MS0;
                        digit_cnt = '0;
                    end
                    else
                        bad = 1'b1;
                end
                default:
                begin
                    if (is_dig)
                    begin
                        if (digit_cnt >= 3'd3)
                            bad = 1'b1;
                        else
                        begin
                            fld_milli = MILLI_W'(fld_milli * 10 + d);
                            digit_cnt = digit_cnt + 1'b1;
                            prs_phase = PH_MS;
                        end
                    end
                    else if (prs_phase == PH_MS && digit_cnt == 3'd3)
                    begin
                        res        = fraction_result();
                        emitted    = 1'b1;
                        rearm_wait = 1'b1;
                    end
                    else
                        bad = 1'b1;
                end
            endcase
            if (bad)
            begin
                emitted    = 1'b1;
                res        = '0;
                rearm_wait = 1'b1;
            end
            else if (!emitted && used_chars != CHARS_MAX)
                used_chars = used_chars + 1'b1;
        end
    endtask

    // Drive one transfer on s_axis, update the model and queue the expected timestamp
    task automatic send_char(input logic [7:0] ch, input logic eot, input logic typed,
                             input cue_res_t want);
        logic     emitted;
        cue_res_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_step(ch, eot, emitted, predicted);
        if (typed)
            pending_stamps.push_back(want);
        else if (emitted)
            pending_stamps.push_back(predicted);
        @(negedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            dir_rows.push_back('{ch: s[i], eot: 1'b0, typed: 1'b0, want: '0});
    endtask

    task automatic add_digits(ref logic [7:0] txt[$], input int n, input logic any_lead);
        for (int i = 0; i < n; i++)
        begin
            if (i == 0 && !any_lead && $urandom_range(9) != 0)
                txt.push_back(CH_ZERO + 8'($urandom_range(5)));
            else
                txt.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    function automatic int field_len();
        if ($urandom_range(9) != 0)
            return 2;
        return $urandom_range(1) ? 3 : 1;
    endfunction

    // Queue one random cue: mostly well-formed, some corrupted, some noise
    task automatic build_cue();
        logic [7:0] txt[$];
        logic [7:0] stop_ch;
        int         kind;
        int         pos;
        int         n;
        logic       cut;
        kind = $urandom_range(99);
        cut  = 1'b0;
        if (kind >= 90)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                char_stream.push_back('{ch: 8'($urandom_range(255)),
                                       eot: ($urandom_range(7) == 0)});
            char_stream.push_back('{ch: 8'($urandom_range(255)), eot: 1'b1});
            return;
        end
        if (kind < 45)
            add_digits(txt, field_len(), 1'b0);
        else
        begin
            add_digits(txt, $urandom_range(1, MAX_HOUR_DIGITS + 1), 1'b1);
            txt.push_back(CH_COLON);
            add_digits(txt, field_len(), 1'b0);
        end
        txt.push_back(CH_COLON);
        add_digits(txt, field_len(), 1'b0);
        txt.push_back(CH_DOT);
        add_digits(txt, ($urandom_range(9) != 0) ? 3 : $urandom_range(0, 4), 1'b1);
        // Corrupt one position: replace, insert a digit, or cut the text short
        if (kind >= 75)
        begin
            pos = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(2))
                0: txt[pos] = 8'($urandom_range(255));
                1: txt.insert(pos, CH_ZERO + 8'($urandom_range(9)));
                default:
                begin
                    while (txt.size() > pos)
                        void'(txt.pop_back());
                    cut = 1'b1;
                end
            endcase
        end
        foreach (txt[i])
            char_stream.push_back('{ch: txt[i], eot: 1'b0});
        // End on end-of-text or on a non-digit, then trail ignored bytes and re-arm
        if (!cut && $urandom_range(1))
        begin
            do
                stop_ch = 8'($urandom_range(255));
            while (stop_ch >= CH_ZERO && stop_ch <= CH_NINE);
            char_stream.push_back('{ch: stop_ch, eot: 1'b0});
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
                char_stream.push_back('{ch: 8'($urandom_range(255)), eot: 1'b0});
        end
        char_stream.push_back('{ch: 8'($urandom_range(255)), eot: 1'b1});
    endtask

    // Receiver: stall at random per current phase
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        cue_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_stamps.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, 64'd0);
            else
            begin
                want = pending_stamps.pop_front();
                if (m_axis_tdata[51:0] !== want.time_ms)
                    report_mismatch("time_ms", 64'(m_axis_tdata[51:0]), 64'(want.time_ms));
                if (m_axis_tuser !== want.valid_res)
                    report_mismatch("valid_res", 64'(m_axis_tuser), 64'(want.valid_res));
                if (m_axis_tdata[56:52] !== want.chars_used)
                    report_mismatch("chars_used", 64'(m_axis_tdata[56:52]),
                                    64'(want.chars_used));
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        char_item_t item;
        int         counted;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        src_idle_pct  = 16;
        snk_stall_pct = 82;
        counted       = 0;
        rearm_wait    = 1'b0;
        clear_parse();

        // Directed rows: end-of-text right after reset, largest hours value,
        // bad first character, then a re-arm
        dir_rows.push_back('{ch: 8'h00, eot: 1'b1, typed: 1'b1, want: '0});
        add_text("999999999:59:59.999");
        dir_rows.push_back('{ch: 8'hFF, eot: 1'b1, typed: 1'b0, want: '0});
        dir_rows.push_back('{ch: CH_COLON, eot: 1'b0, typed: 1'b1, want: '0});
        dir_rows.push_back('{ch: 8'h00, eot: 1'b1, typed: 1'b0, want: '0});

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].want);

        // Random cues over three idling phases
        while (counted < ITEM_GOAL)
        begin
            if (counted < ITEM_GOAL / 3)
            begin
                src_idle_pct  = 16;
                snk_stall_pct = 82;
            end
            else if (counted < 2 * ITEM_GOAL / 3)
            begin
                src_idle_pct  = 82;
                snk_stall_pct = 16;
            end
            else
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            if (char_stream.size() == 0)
                build_cue();
            item = char_stream.pop_front();
            counted++;
            send_char(item.ch, item.eot, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline latency
        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
